// ===== rtl/sha256_pkg.sv =====
// Constants and round functions shared by the SHA-256 engine.
`default_nettype none

package sha256_pkg;

  localparam int unsigned RoundCount = 64;

  // Input actions.
  localparam logic ACT_APPEND = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  localparam logic [7:0] PadMarker = 8'h80;

  function automatic logic [31:0] init_hash(input logic [2:0] idx);
    logic [31:0] v;
    unique case (idx)
      3'd0: v = 32'h6a09e667;
      3'd1: v = 32'hbb67ae85;
      3'd2: v = 32'h3c6ef372;
      3'd3: v = 32'ha54ff53a;
      3'd4: v = 32'h510e527f;
      3'd5: v = 32'h9b05688c;
      3'd6: v = 32'h1f83d9ab;
      3'd7: v = 32'h5be0cd19;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] v;
    unique case (idx)
      6'd0:  v = 32'h428a2f98;  6'd1:  v = 32'h71374491;
      6'd2:  v = 32'hb5c0fbcf;  6'd3:  v = 32'he9b5dba5;
      6'd4:  v = 32'h3956c25b;  6'd5:  v = 32'h59f111f1;
      6'd6:  v = 32'h923f82a4;  6'd7:  v = 32'hab1c5ed5;
      6'd8:  v = 32'hd807aa98;  6'd9:  v = 32'h12835b01;
      6'd10: v = 32'h243185be;  6'd11: v = 32'h550c7dc3;
      6'd12: v = 32'h72be5d74;  6'd13: v = 32'h80deb1fe;
      6'd14: v = 32'h9bdc06a7;  6'd15: v = 32'hc19bf174;
      6'd16: v = 32'he49b69c1;  6'd17: v = 32'hefbe4786;
      6'd18: v = 32'h0fc19dc6;  6'd19: v = 32'h240ca1cc;
      6'd20: v = 32'h2de92c6f;  6'd21: v = 32'h4a7484aa;
      6'd22: v = 32'h5cb0a9dc;  6'd23: v = 32'h76f988da;
      6'd24: v = 32'h983e5152;  6'd25: v = 32'ha831c66d;
      6'd26: v = 32'hb00327c8;  6'd27: v = 32'hbf597fc7;
      6'd28: v = 32'hc6e00bf3;  6'd29: v = 32'hd5a79147;
      6'd30: v = 32'h06ca6351;  6'd31: v = 32'h14292967;
      6'd32: v = 32'h27b70a85;  6'd33: v = 32'h2e1b2138;
      6'd34: v = 32'h4d2c6dfc;  6'd35: v = 32'h53380d13;
      6'd36: v = 32'h650a7354;  6'd37: v = 32'h766a0abb;
      6'd38: v = 32'h81c2c92e;  6'd39: v = 32'h92722c85;
      6'd40: v = 32'ha2bfe8a1;  6'd41: v = 32'ha81a664b;
      6'd42: v = 32'hc24b8b70;  6'd43: v = 32'hc76c51a3;
      6'd44: v = 32'hd192e819;  6'd45: v = 32'hd6990624;
      6'd46: v = 32'hf40e3585;  6'd47: v = 32'h106aa070;
      6'd48: v = 32'h19a4c116;  6'd49: v = 32'h1e376c08;
      6'd50: v = 32'h2748774c;  6'd51: v = 32'h34b0bcb5;
      6'd52: v = 32'h391c0cb3;  6'd53: v = 32'h4ed8aa4a;
      6'd54: v = 32'h5b9cca4f;  6'd55: v = 32'h682e6ff3;
      6'd56: v = 32'h748f82ee;  6'd57: v = 32'h78a5636f;
      6'd58: v = 32'h84c87814;  6'd59: v = 32'h8cc70208;
      6'd60: v = 32'h90befffa;  6'd61: v = 32'ha4506ceb;
      6'd62: v = 32'hbef9a3f7;  6'd63: v = 32'hc67178f2;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] big_sigma0(input logic [31:0] x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic logic [31:0] big_sigma1(input logic [31:0] x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic logic [31:0] small_sigma0(input logic [31:0] x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic logic [31:0] small_sigma1(input logic [31:0] x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
  endfunction

endpackage

`default_nettype wire

// ===== rtl/sha256_hash_engine.sv =====
// SHA-256 engine: byte input, one compression round per cycle, digest out as eight words.
//
//   channel | direction | handshake          | beat contents
//   --------+-----------+--------------------+-------------------------------------
//   in      | into      | in_valid/in_stall  | action, data_byte
//   out     | out of    | out_valid/out_stall| digest_word, word_index, last
//
// An append beat that completes a 64-byte block is followed by a busy phase of 64 rounds
// on the shared round unit and one chain fold.
// A finish beat pads one byte per cycle up to the block end, runs one or two compressions,
// then presents eight output beats, each held until out_stall is low.
// in_stall is high whenever the engine is not idle. Reset restores the initial hash values
// and an empty message; the message buffer and working variables are not reset.
`default_nettype none

module sha256_hash_engine
  import sha256_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        action,
  input  wire logic [7:0]  data_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_ROUND = 3'd2;
  localparam logic [2:0] S_FOLD  = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]   state;
  logic [5:0]   fill;        // bytes held in the current block
  logic [63:0]  bit_length;
  logic [63:0]  len_sh;      // length bytes still to be padded, top byte first
  logic         marker;      // the 0x80 byte is still to be written
  logic         extra;       // padding spills into a second block
  logic         final_blk;   // the running compression is the last of the message
  logic         pad;         // padding in progress
  logic [5:0]   rnd;
  logic [2:0]   idx;

  // Block buffer and message schedule share one shift line: bytes enter at the bottom,
  // and during the rounds each new schedule word enters while the oldest leaves the top.
  logic [511:0] msg;
  logic [31:0]  chain [8];
  logic [31:0]  va, vb, vc, vd, ve, vf, vg, vh;

  logic [31:0]  w0, w1, w9, w14, w_new;
  logic [31:0]  t1, t2;
  logic [7:0]   pad_byte;
  logic         len_phase;

  assign w0  = msg[511:480];
  assign w1  = msg[479:448];
  assign w9  = msg[223:192];
  assign w14 = msg[63:32];

  assign w_new = small_sigma1(w14) + w9 + small_sigma0(w1) + w0;
  assign t1 = vh + big_sigma1(ve) + ((ve & vf) ^ (~ve & vg)) + round_k(rnd) + w0;
  assign t2 = big_sigma0(va) + ((va & vb) ^ (va & vc) ^ (vb & vc));

  assign len_phase = !marker && !extra && (fill >= 6'd56);

  always_comb begin
    if (marker) begin
      pad_byte = PadMarker;
    end else if (len_phase) begin
      pad_byte = len_sh[63:56];
    end else begin
      pad_byte = 8'h00;
    end
  end

  assign in_stall    = (state != S_IDLE);
  assign out_valid   = (state == S_OUT);
  assign digest_word = chain[0];
  assign word_index  = idx;
  assign last        = (idx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill       <= '0;
      bit_length <= '0;
      marker     <= 1'b0;
      extra      <= 1'b0;
      final_blk  <= 1'b0;
      pad        <= 1'b0;
      rnd        <= '0;
      idx        <= '0;
      for (int i = 0; i < 8; i++) begin
        chain[i] <= init_hash(3'(i));
      end
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (action == ACT_APPEND) begin
              msg        <= {msg[503:0], data_byte};
              fill       <= fill + 6'd1;
              bit_length <= bit_length + 64'd8;
              if (fill == 6'd63) begin
                {va, vb, vc, vd} <= {chain[0], chain[1], chain[2], chain[3]};
                {ve, vf, vg, vh} <= {chain[4], chain[5], chain[6], chain[7]};
                final_blk <= 1'b0;
                rnd       <= '0;
                state     <= S_ROUND;
              end
            end else begin
              len_sh     <= bit_length;
              bit_length <= '0;
              marker     <= 1'b1;
              extra      <= (fill >= 6'd56);
              pad        <= 1'b1;
              state      <= S_PAD;
            end
          end
        end
        S_PAD: begin
          msg    <= {msg[503:0], pad_byte};
          fill   <= fill + 6'd1;
          marker <= 1'b0;
          if (len_phase) begin
            len_sh <= {len_sh[55:0], 8'h00};
          end
          if (fill == 6'd63) begin
            {va, vb, vc, vd} <= {chain[0], chain[1], chain[2], chain[3]};
            {ve, vf, vg, vh} <= {chain[4], chain[5], chain[6], chain[7]};
            final_blk <= !extra;
            extra     <= 1'b0;
            rnd       <= '0;
            state     <= S_ROUND;
          end
        end
        S_ROUND: begin
          msg <= {msg[479:0], w_new};
          {vb, vc, vd} <= {va, vb, vc};
          {vf, vg, vh} <= {ve, vf, vg};
          va  <= t1 + t2;
          ve  <= vd + t1;
          rnd <= rnd + 6'd1;
          if (rnd == 6'(RoundCount - 1)) begin
            state <= S_FOLD;
          end
        end
        S_FOLD: begin
          chain[0] <= chain[0] + va;
          chain[1] <= chain[1] + vb;
          chain[2] <= chain[2] + vc;
          chain[3] <= chain[3] + vd;
          chain[4] <= chain[4] + ve;
          chain[5] <= chain[5] + vf;
          chain[6] <= chain[6] + vg;
          chain[7] <= chain[7] + vh;
          if (final_blk) begin
            idx   <= '0;
            state <= S_OUT;
          end else if (pad) begin
            state <= S_PAD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            idx <= idx + 3'd1;
            if (idx == 3'd7) begin
              for (int i = 0; i < 8; i++) begin
                chain[i] <= init_hash(3'(i));
              end
              pad   <= 1'b0;
              state <= S_IDLE;
            end else begin
              // The chain rotates so that the word on the port is always at the head.
              for (int i = 0; i < 7; i++) begin
                chain[i] <= chain[i + 1];
              end
              chain[7] <= chain[0];
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
